// ===== hw/rtl/cvc_pkg.sv =====
// shared types, constants and shift functions of the character cipher unit
package cvc_pkg;

  // key store geometry
  localparam int KEY_DEPTH = 32;
  localparam int KEY_IDX_W = $clog2(KEY_DEPTH);
  localparam int KEY_LEN_W = 6;
  localparam int SHIFT_W   = 5;
  localparam int CHAR_W    = 8;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // character constants
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'd65;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'd90;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'd97;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'd122;
  localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'd32;
  localparam logic [CHAR_W-1:0] ALPHA_LEN  = 8'd26;

  // configuration register width and index codes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CIPHER_MODE   = 3'd0,
    CFG_DECRYPT_MODE  = 3'd1,
    CFG_CAESAR_LEFT   = 3'd2,
    CFG_CAESAR_OFFSET = 3'd3,
    CFG_KEY_LENGTH    = 3'd4
  } cfg_idx_e;

  // input opcodes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_KEY   = 2'd1,
    OP_CHAR  = 2'd2
  } op_e;

  // cipher modes
  typedef enum logic [1:0] {
    MODE_CAESAR   = 2'd0,
    MODE_VIGENERE = 2'd1,
    MODE_SALTED   = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]           cipher_mode;
    logic                 decrypt_mode;
    logic                 caesar_left;
    logic [SHIFT_W-1:0]   caesar_offset;
    logic [KEY_LEN_W-1:0] key_length;
  } cfg_t;

  // one queued character: upper-cased byte and its key shift
  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [SHIFT_W-1:0] amt;
  } q_entry_t;

  // add with wrap back into the alphabet
  function automatic logic [CHAR_W-1:0] shift_right(logic [CHAR_W-1:0] c,
                                                    logic [SHIFT_W-1:0] amt);
    logic [CHAR_W-1:0] v;
    v = c + {{(CHAR_W-SHIFT_W){1'b0}}, amt};
    if (v > CH_UPPER_Z) begin
      v = v - ALPHA_LEN;
    end
    return v;
  endfunction

  // subtract with wrap back into the alphabet
  function automatic logic [CHAR_W-1:0] shift_left(logic [CHAR_W-1:0] c,
                                                   logic [SHIFT_W-1:0] amt);
    logic [CHAR_W-1:0] v;
    v = c - {{(CHAR_W-SHIFT_W){1'b0}}, amt};
    if (v < CH_UPPER_A) begin
      v = v + ALPHA_LEN;
    end
    return v;
  endfunction

  function automatic logic [CHAR_W-1:0] caesar_stage(logic [CHAR_W-1:0] c, cfg_t cfg);
    logic left;
    left = cfg.caesar_left ^ cfg.decrypt_mode;
    return left ? shift_left(c, cfg.caesar_offset) : shift_right(c, cfg.caesar_offset);
  endfunction

  function automatic logic [CHAR_W-1:0] vigenere_stage(logic [CHAR_W-1:0] c,
                                                       logic [SHIFT_W-1:0] amt,
                                                       cfg_t cfg);
    return cfg.decrypt_mode ? shift_left(c, amt) : shift_right(c, amt);
  endfunction

  function automatic logic [CHAR_W-1:0] upper_case(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    v = c;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      v = c - CASE_DIFF;
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/caesar_vigenere_char_cipher_unit.sv =====
// Top level of the character cipher unit: config registers, front, queue and back.
// Throughput: one item per cycle while not full; the front key index update sets this.
// Path: an accepted character is written into the queue, then ciphered into the
// output register that drives out_char_o; start and key write beats give no result.
// Reset: config to its reset values, key index 0, queues empty; key store undefined.
// The config port is always ready; writes to unknown indexes are dropped.
module caesar_vigenere_char_cipher_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [1:0]                         opcode_i,
  input  logic [cvc_pkg::KEY_IDX_W-1:0]      key_address_i,
  input  logic [cvc_pkg::SHIFT_W-1:0]        key_shift_i,
  input  logic [cvc_pkg::CHAR_W-1:0]         data_char_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [cvc_pkg::CHAR_W-1:0]         out_char_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cvc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cvc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  cvc_pkg::cfg_t     cfg_q, cfg_d;
  cvc_pkg::q_entry_t q_push_data, q_pop_data;
  logic              q_push, q_pop, q_full, q_empty;
  logic              accept;

  assign cfg_ready_o = 1'b1;

  // config register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cvc_pkg::cfg_idx_e'(cfg_index_i))
        cvc_pkg::CFG_CIPHER_MODE:   cfg_d.cipher_mode   = cfg_data_i[1:0];
        cvc_pkg::CFG_DECRYPT_MODE:  cfg_d.decrypt_mode  = cfg_data_i[0];
        cvc_pkg::CFG_CAESAR_LEFT:   cfg_d.caesar_left   = cfg_data_i[0];
        cvc_pkg::CFG_CAESAR_OFFSET: cfg_d.caesar_offset = cfg_data_i[cvc_pkg::SHIFT_W-1:0];
        cvc_pkg::CFG_KEY_LENGTH:    cfg_d.key_length    = cfg_data_i[cvc_pkg::KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cipher_mode   <= cvc_pkg::MODE_CAESAR;
      cfg_q.decrypt_mode  <= 1'b0;
      cfg_q.caesar_left   <= 1'b0;
      cfg_q.caesar_offset <= '0;
      cfg_q.key_length    <= cvc_pkg::KEY_LEN_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input beat accepted while the queue has room
  assign full   = q_full;
  assign accept = push & ~q_full;

  cvc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .opcode_i      (opcode_i),
    .key_address_i (key_address_i),
    .key_shift_i   (key_shift_i),
    .data_char_i   (data_char_i),
    .q_push_o      (q_push),
    .q_data_o      (q_push_data)
  );

  cvc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .empty_o     (q_empty)
  );

  cvc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_data_i   (q_pop_data),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_char_o (out_char_o)
  );

endmodule

// ===== hw/rtl/cvc_queue.sv =====
// short fifo between the classifying front and the cipher back
module cvc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cvc_pkg::q_entry_t  push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output cvc_pkg::q_entry_t  pop_data_o,
  output logic               empty_o
);

  cvc_pkg::q_entry_t                mem_q [cvc_pkg::QUEUE_DEPTH];
  logic [cvc_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [cvc_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [cvc_pkg::QCNT_W-1:0]       count_q, count_d;
  logic                             do_push, do_pop;

  assign full_o     = (count_q == cvc_pkg::QCNT_W'(cvc_pkg::QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == cvc_pkg::QPTR_W'(cvc_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == cvc_pkg::QPTR_W'(cvc_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/cvc_front.sv =====
// front end: opcode decode, key store, key index and upper-casing
module cvc_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cvc_pkg::cfg_t                   cfg_i,
  input  logic                            accept_i,
  input  logic [1:0]                      opcode_i,
  input  logic [cvc_pkg::KEY_IDX_W-1:0]   key_address_i,
  input  logic [cvc_pkg::SHIFT_W-1:0]     key_shift_i,
  input  logic [cvc_pkg::CHAR_W-1:0]      data_char_i,
  output logic                            q_push_o,
  output cvc_pkg::q_entry_t               q_data_o
);

  logic [cvc_pkg::SHIFT_W-1:0]   key_store_q [cvc_pkg::KEY_DEPTH];
  logic [cvc_pkg::KEY_IDX_W-1:0] key_index_q, key_index_d;
  logic [cvc_pkg::KEY_LEN_W-1:0] len_eff;
  logic [cvc_pkg::KEY_LEN_W-1:0] index_inc;
  logic [cvc_pkg::CHAR_W-1:0]    upper;
  logic                          is_space;
  logic                          advance;
  logic                          is_char, is_key, is_start;

  // opcode decode
  always_comb begin
    is_char  = 1'b0;
    is_key   = 1'b0;
    is_start = 1'b0;
    case (cvc_pkg::op_e'(opcode_i))
      cvc_pkg::OP_START: is_start = 1'b1;
      cvc_pkg::OP_KEY:   is_key   = 1'b1;
      cvc_pkg::OP_CHAR:  is_char  = 1'b1;
      default: ;
    endcase
  end

  assign upper    = cvc_pkg::upper_case(data_char_i);
  assign is_space = (upper == cvc_pkg::CH_SPACE);

  // whether this character consumes a key entry
  always_comb begin
    advance = 1'b0;
    case (cvc_pkg::mode_e'(cfg_i.cipher_mode))
      cvc_pkg::MODE_VIGENERE: advance = ~is_space;
      cvc_pkg::MODE_SALTED: begin
        if (cfg_i.decrypt_mode) begin
          advance = ~is_space;
        end else begin
          // second stage skipped when the caesar stage lands on a space
          advance = ~is_space &
                    (cvc_pkg::caesar_stage(upper, cfg_i) != cvc_pkg::CH_SPACE);
        end
      end
      default: advance = 1'b0;
    endcase
  end

  // effective key length, clamped to 1..depth
  always_comb begin
    len_eff = cfg_i.key_length;
    if (cfg_i.key_length == '0) begin
      len_eff = cvc_pkg::KEY_LEN_W'(1);
    end else if (cfg_i.key_length > cvc_pkg::KEY_LEN_W'(cvc_pkg::KEY_DEPTH)) begin
      len_eff = cvc_pkg::KEY_LEN_W'(cvc_pkg::KEY_DEPTH);
    end
  end

  assign index_inc = {1'b0, key_index_q} + 1'b1;

  // key index next value
  always_comb begin
    key_index_d = key_index_q;
    if (accept_i && is_start) begin
      key_index_d = '0;
    end else if (accept_i && is_char && advance) begin
      key_index_d = (index_inc >= len_eff) ? '0 : index_inc[cvc_pkg::KEY_IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_index_q <= '0;
    end else begin
      key_index_q <= key_index_d;
    end
  end

  // key entry writes
  always_ff @(posedge clk_i) begin
    if (accept_i && is_key) begin
      key_store_q[key_address_i] <= key_shift_i;
    end
  end

  // hand the character beat to the back end
  assign q_push_o     = accept_i & is_char;
  assign q_data_o.ch  = upper;
  assign q_data_o.amt = key_store_q[key_index_q];

endmodule

// ===== hw/rtl/cvc_back.sv =====
// back end: applies the cipher stages and holds the result register
module cvc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cvc_pkg::cfg_t               cfg_i,
  input  logic                        q_empty_i,
  input  cvc_pkg::q_entry_t           q_data_i,
  output logic                        q_pop_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [cvc_pkg::CHAR_W-1:0]  out_char_o
);

  logic                       out_valid_q, out_valid_d;
  logic [cvc_pkg::CHAR_W-1:0] out_char_q, out_char_d;
  logic [cvc_pkg::CHAR_W-1:0] first;
  logic                       take;

  // cipher datapath
  always_comb begin
    out_char_d = q_data_i.ch;
    first      = '0;
    if (q_data_i.ch != cvc_pkg::CH_SPACE) begin
      case (cvc_pkg::mode_e'(cfg_i.cipher_mode))
        cvc_pkg::MODE_CAESAR:   out_char_d = cvc_pkg::caesar_stage(q_data_i.ch, cfg_i);
        cvc_pkg::MODE_VIGENERE: out_char_d =
          cvc_pkg::vigenere_stage(q_data_i.ch, q_data_i.amt, cfg_i);
        cvc_pkg::MODE_SALTED: begin
          if (cfg_i.decrypt_mode) begin
            first      = cvc_pkg::vigenere_stage(q_data_i.ch, q_data_i.amt, cfg_i);
            out_char_d = (first == cvc_pkg::CH_SPACE) ? first :
                         cvc_pkg::caesar_stage(first, cfg_i);
          end else begin
            first      = cvc_pkg::caesar_stage(q_data_i.ch, cfg_i);
            out_char_d = (first == cvc_pkg::CH_SPACE) ? first :
                         cvc_pkg::vigenere_stage(first, q_data_i.amt, cfg_i);
          end
        end
        default: out_char_d = q_data_i.ch;
      endcase
    end
  end

  // output register refills whenever it is free or being drained
  assign take        = ~q_empty_i & (~out_valid_q | pop_i);
  assign q_pop_o     = take;
  assign out_valid_d = take | (out_valid_q & ~pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_char_q <= out_char_d;
    end
  end

  assign empty_o    = ~out_valid_q;
  assign out_char_o = out_char_q;

endmodule
